// ===== rtl/gpp_pkg.sv =====
// ============================================================================
// gpp_pkg - shared types and constants for glyph placement and pixel packing
// Command and result transaction layouts, opcodes, register indexes and
// register reset values.
// ============================================================================
`default_nettype none

package gpp_pkg;

    localparam int BYTE_BITS        = 8;
    localparam int MAX_SOURCE_WIDTH = 32;
    localparam int MAX_SOURCE_ROWS  = 32;
    localparam int MAX_CELL_SIZE    = 32;

    // width of signed coordinate differences inside the cell
    localparam int COORD_W = 10;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam logic [2:0] REG_CELL_WIDTH     = 3'd0;
    localparam logic [2:0] REG_CELL_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_BITS_PER_PIXEL = 3'd2;
    localparam logic [2:0] REG_SOURCE_LEFT    = 3'd3;
    localparam logic [2:0] REG_SOURCE_TOP     = 3'd4;
    localparam logic [2:0] REG_BASELINE_ROW   = 3'd5;
    localparam logic [2:0] REG_SOURCE_WIDTH   = 3'd6;
    localparam logic [2:0] REG_SOURCE_ROWS    = 3'd7;

    localparam logic [5:0] RST_CELL_WIDTH     = 6'd8;
    localparam logic [5:0] RST_CELL_HEIGHT    = 6'd16;
    localparam logic [3:0] RST_BITS_PER_PIXEL = 4'd4;

    typedef struct packed {
        logic       opcode;
        logic [4:0] source_row;
        logic [4:0] source_col;
        logic [7:0] pixel_value;
    } cmd_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_byte;
        logic       error;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/glyph_place_and_pixel_pack_top.sv =====
// ============================================================================
// glyph_place_and_pixel_pack_top - glyph cell placement and pixel packing
// Places a stored grayscale source bitmap into a glyph cell and packs the
// cell, in raster order, into bytes of 1, 2, 4 or 8 bit pixels.
// ============================================================================
// Usage:
//   Command channel: a transaction is taken on a rising edge with start high
//   and busy low. A load writes one source pixel into the source store in
//   that same cycle and never raises busy, so loads go one per cycle.
//   An emit with a valid pixel depth raises busy and walks 8/bpp cell pixels,
//   reading the source store one pixel per cycle while the pixel
//   read in the previous cycle is shifted into the byte. The result strobe
//   is registered once the last pixel has been folded in; busy drops as the
//   strobe rises, so a new command is taken only after the byte is delivered.
//   An emit with an invalid depth answers in the cycle after it is taken.
//   Result channel: result_valid is high for exactly one cycle per emit;
//   the receiver has to take it then, there is no back pressure.
//   Config channel: cfg_ready is always high; write only while idle.
//   Reset clears the cursor, the control state and the config registers to
//   their defaults. The source store is not cleared: load every pixel inside
//   the source window before emitting.
// ============================================================================
`default_nettype none

module glyph_place_and_pixel_pack_top #(
    parameter int MAX_SOURCE_WIDTH = gpp_pkg::MAX_SOURCE_WIDTH,
    parameter int MAX_SOURCE_ROWS  = gpp_pkg::MAX_SOURCE_ROWS,
    parameter int MAX_CELL_SIZE    = gpp_pkg::MAX_CELL_SIZE
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire gpp_pkg::cmd_t    cmd,
    output logic                  result_valid,
    output gpp_pkg::result_t      result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [6:0]       cfg_data
);

    localparam int DEPTH  = MAX_SOURCE_WIDTH * MAX_SOURCE_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CUR_W  = $clog2(MAX_CELL_SIZE + 1);
    localparam int SRC_W  = $clog2(((MAX_SOURCE_WIDTH > MAX_SOURCE_ROWS) ?
                                    MAX_SOURCE_WIDTH : MAX_SOURCE_ROWS) + 1);
    localparam int CO_W   = gpp_pkg::COORD_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [5:0]        cell_width_reg;
    logic [5:0]        cell_height_reg;
    logic [3:0]        bpp_reg;
    logic signed [6:0] source_left_reg;
    logic signed [6:0] source_top_reg;
    logic [5:0]        baseline_row_reg;
    logic [5:0]        source_width_reg;
    logic [5:0]        source_rows_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg   <= gpp_pkg::RST_CELL_WIDTH;
            cell_height_reg  <= gpp_pkg::RST_CELL_HEIGHT;
            bpp_reg          <= gpp_pkg::RST_BITS_PER_PIXEL;
            source_left_reg  <= '0;
            source_top_reg   <= '0;
            baseline_row_reg <= '0;
            source_width_reg <= '0;
            source_rows_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gpp_pkg::REG_CELL_WIDTH:     cell_width_reg   <= cfg_data[5:0];
                gpp_pkg::REG_CELL_HEIGHT:    cell_height_reg  <= cfg_data[5:0];
                gpp_pkg::REG_BITS_PER_PIXEL: bpp_reg          <= cfg_data[3:0];
                gpp_pkg::REG_SOURCE_LEFT:    source_left_reg  <= $signed(cfg_data);
                gpp_pkg::REG_SOURCE_TOP:     source_top_reg   <= $signed(cfg_data);
                gpp_pkg::REG_BASELINE_ROW:   baseline_row_reg <= cfg_data[5:0];
                gpp_pkg::REG_SOURCE_WIDTH:   source_width_reg <= cfg_data[5:0];
                gpp_pkg::REG_SOURCE_ROWS:    source_rows_reg  <= cfg_data[5:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // effective geometry
    // ------------------------------------------------------------------
    logic [CUR_W-1:0]         cw;
    logic [CUR_W-1:0]         ch;
    logic [SRC_W-1:0]         sw;
    logic [SRC_W-1:0]         sr;
    logic signed [CO_W-1:0]   left_s;
    logic signed [CO_W-1:0]   top_row_s;
    logic [3:0]               ppb;
    logic                     bpp_ok;

    always_comb
    begin
        if (cell_width_reg == '0)
            cw = CUR_W'(1);
        else if (int'(cell_width_reg) > MAX_CELL_SIZE)
            cw = CUR_W'(MAX_CELL_SIZE);
        else
            cw = CUR_W'(cell_width_reg);

        if (cell_height_reg == '0)
            ch = CUR_W'(1);
        else if (int'(cell_height_reg) > MAX_CELL_SIZE)
            ch = CUR_W'(MAX_CELL_SIZE);
        else
            ch = CUR_W'(cell_height_reg);

        if (int'(source_width_reg) > MAX_SOURCE_WIDTH)
            sw = SRC_W'(MAX_SOURCE_WIDTH);
        else
            sw = SRC_W'(source_width_reg);

        if (int'(source_rows_reg) > MAX_SOURCE_ROWS)
            sr = SRC_W'(MAX_SOURCE_ROWS);
        else
            sr = SRC_W'(source_rows_reg);
    end

    assign left_s    = CO_W'(source_left_reg);
    assign top_row_s = $signed(CO_W'(baseline_row_reg)) - CO_W'(source_top_reg);

    always_comb
    begin
        unique case (bpp_reg)
            4'd1:    begin ppb = 4'd8; bpp_ok = 1'b1; end
            4'd2:    begin ppb = 4'd4; bpp_ok = 1'b1; end
            4'd4:    begin ppb = 4'd2; bpp_ok = 1'b1; end
            4'd8:    begin ppb = 4'd1; bpp_ok = 1'b1; end
            default: begin ppb = 4'd0; bpp_ok = 1'b0; end
        endcase
    end

    // ------------------------------------------------------------------
    // source store
    // ------------------------------------------------------------------
    logic [7:0]        mem [DEPTH];
    logic [7:0]        rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= cmd.pixel_value;
        rdata_reg <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic [1:0]       state_reg,  state_next;
    logic [CUR_W-1:0] cur_x_reg,  cur_x_next;
    logic [CUR_W-1:0] cur_y_reg,  cur_y_next;
    logic [3:0]       cnt_reg,    cnt_next;
    logic [7:0]       acc_reg,    acc_next;
    logic             err_reg,    err_next;
    logic             pend_reg,   pend_next;
    logic             pend_in_reg, pend_in_next;
    logic             res_valid_reg, res_valid_next;
    gpp_pkg::result_t res_reg,    res_next;

    logic                   accept;
    logic                   load_in_range;
    logic                   cur_outside;
    logic                   pix_valid;
    logic                   in_win;
    logic signed [CO_W-1:0] dx;
    logic signed [CO_W-1:0] dy;
    logic [7:0]             pix;
    logic [7:0]             acc_shift;
    logic [CUR_W-1:0]       x_inc;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    assign load_in_range = (int'(cmd.source_row) < MAX_SOURCE_ROWS) &&
                           (int'(cmd.source_col) < MAX_SOURCE_WIDTH);
    assign mem_we  = accept && (cmd.opcode == gpp_pkg::OP_LOAD) && load_in_range;
    assign wr_addr = ADDR_W'(ADDR_W'(cmd.source_row) * ADDR_W'(MAX_SOURCE_WIDTH) +
                             ADDR_W'(cmd.source_col));

    // window test for the pixel under the cursor
    assign dx = $signed(CO_W'(cur_x_reg)) - left_s;
    assign dy = $signed(CO_W'(cur_y_reg)) - top_row_s;
    assign in_win = (dx >= 0) && (dx < $signed(CO_W'(sw))) &&
                    (dy >= 0) && (dy < $signed(CO_W'(sr)));
    assign rd_addr = ADDR_W'(ADDR_W'(dy) * ADDR_W'(MAX_SOURCE_WIDTH) + ADDR_W'(dx));

    assign pix_valid   = (cur_y_reg < ch);
    assign cur_outside = (cur_x_reg >= cw) || (cur_y_reg >= ch);
    assign x_inc       = cur_x_reg + CUR_W'(1);

    always_comb
    begin
        unique case (bpp_reg)
            4'd1:    begin pix = 8'(rdata_reg >> 7); acc_shift = {acc_reg[6:0], 1'b0}; end
            4'd2:    begin pix = 8'(rdata_reg >> 6); acc_shift = {acc_reg[5:0], 2'b0}; end
            4'd4:    begin pix = 8'(rdata_reg >> 4); acc_shift = {acc_reg[3:0], 4'b0}; end
            default: begin pix = rdata_reg;          acc_shift = 8'd0;                 end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        pend_next      = 1'b0;
        pend_in_next   = 1'b0;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.opcode == gpp_pkg::OP_EMIT))
                begin
                    if (!bpp_ok)
                    begin
                        cur_x_next           = '0;
                        cur_y_next           = '0;
                        res_valid_next       = 1'b1;
                        res_next.packed_byte = 8'd0;
                        res_next.last_byte   = 1'b0;
                        res_next.error       = 1'b1;
                    end
                    else
                    begin
                        if (cur_outside)
                        begin
                            cur_x_next = '0;
                            cur_y_next = '0;
                        end
                        cnt_next   = ppb;
                        acc_next   = 8'd0;
                        err_next   = 1'b0;
                        state_next = ST_RUN;
                    end
                end
            end

            ST_RUN:
            begin
                // fold in the pixel read last cycle
                if (pend_reg)
                    acc_next = acc_shift | (pend_in_reg ? pix : 8'd0);

                if (cnt_reg != 4'd0)
                begin
                    cnt_next     = cnt_reg - 4'd1;
                    pend_next    = 1'b1;
                    pend_in_next = pix_valid && in_win;
                    if (pix_valid)
                    begin
                        if (x_inc >= cw)
                        begin
                            cur_x_next = '0;
                            cur_y_next = cur_y_reg + CUR_W'(1);
                        end
                        else
                            cur_x_next = x_inc;
                    end
                    else
                        err_next = 1'b1;
                end
                else
                begin
                    // all pixels issued and folded in: deliver the byte
                    res_valid_next       = 1'b1;
                    res_next.packed_byte = acc_next;
                    res_next.last_byte   = (cur_y_reg == ch);
                    res_next.error       = err_reg;
                    if (cur_y_reg == ch)
                    begin
                        cur_x_next = '0;
                        cur_y_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cnt_reg       <= '0;
            err_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            pend_in_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            pend_reg      <= pend_next;
            pend_in_reg   <= pend_in_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

// ===== rtl/gpp_checker.sv =====
// ============================================================================
// gpp_checker - port-level checks for glyph placement and pixel packing
// Watches the command, result and busy ports and flags ordering slips.
// ============================================================================
`default_nettype none

module gpp_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire gpp_pkg::cmd_t    cmd,
    input wire logic             result_valid,
    input wire gpp_pkg::result_t result
);

    // a result only follows an emit transaction or a busy stretch
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            $past(busy) || $past(start && !busy && (cmd.opcode == gpp_pkg::OP_EMIT)))
        else $error("result strobe without an emit in progress");

    // a load transaction never produces a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.opcode == gpp_pkg::OP_LOAD)) |=> !result_valid)
        else $error("result strobe after a load");

    // the end of an emit always delivers its byte
    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy dropped without a result");

    // a partial last byte is always flagged as the cell end
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.error && (result.packed_byte != 8'd0)) |->
            result.last_byte)
        else $error("error with data but not marked last");

endmodule

bind glyph_place_and_pixel_pack_top gpp_checker u_gpp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire

// ===== verif/glyph_place_and_pixel_pack_top_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// glyph_place_and_pixel_pack_top_tb - self-checking bench for glyph packing
// Drives load and emit commands with random gaps, rewrites the cell and
// window registers between phases while the block is idle, and predicts
// every packed byte from a local model of the store, cursor and registers.
// Each result is compared field by field with the oldest predicted byte.
// ============================================================================

module glyph_place_and_pixel_pack_top_tb;

    localparam int CLK_PERIOD  = 20;
    localparam int RAND_ITEMS  = 1900;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 16;
    localparam int STORE_SIZE  = gpp_pkg::MAX_SOURCE_ROWS * gpp_pkg::MAX_SOURCE_WIDTH;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    gpp_pkg::cmd_t    cmd       = '0;
    logic             cfg_valid = 1'b0;
    logic [2:0]       cfg_index = '0;
    logic [6:0]       cfg_data  = '0;
    logic             busy;
    logic             result_valid;
    logic             cfg_ready;
    gpp_pkg::result_t result;

    glyph_place_and_pixel_pack_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // model state: register copies, source pixels, cell cursor
    logic [6:0] cell_cfg [8] = '{7'd8, 7'd16, 7'd4, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
    logic [7:0] glyph_px [STORE_SIZE];
    int         pen_x = 0;
    int         pen_y = 0;

    // generator side: which store entries hold a value, planned register values
    bit         src_loaded [STORE_SIZE];
    logic [6:0] phase_cfg [8];

    gpp_pkg::cmd_t    cmd_backlog [$];
    gpp_pkg::result_t expected_bytes [$];
    int               cmds_queued = 0;
    int               cmds_taken  = 0;
    int               gen_items   = 0;
    int               failures    = 0;
    int               hold_off    = 0;
    bit               no_idle     = 1'b0;

    function automatic logic [6:0] reg_mask(input logic [2:0] idx);
        case (idx)
            gpp_pkg::REG_BITS_PER_PIXEL:                       return 7'h0F;
            gpp_pkg::REG_SOURCE_LEFT, gpp_pkg::REG_SOURCE_TOP: return 7'h7F;
            default:                                           return 7'h3F;
        endcase
    endfunction

    function automatic void decode_cell(output int cw, output int ch, output int bpp,
                                        output int left, output int top_row,
                                        output int sw, output int sr);
        cw = int'(cell_cfg[gpp_pkg::REG_CELL_WIDTH][5:0]);
        ch = int'(cell_cfg[gpp_pkg::REG_CELL_HEIGHT][5:0]);
        if (cw < 1) cw = 1;
        if (cw > gpp_pkg::MAX_CELL_SIZE) cw = gpp_pkg::MAX_CELL_SIZE;
        if (ch < 1) ch = 1;
        if (ch > gpp_pkg::MAX_CELL_SIZE) ch = gpp_pkg::MAX_CELL_SIZE;
        bpp     = int'(cell_cfg[gpp_pkg::REG_BITS_PER_PIXEL][3:0]);
        left    = int'($signed(cell_cfg[gpp_pkg::REG_SOURCE_LEFT]));
        top_row = int'(cell_cfg[gpp_pkg::REG_BASELINE_ROW][5:0])
                  - int'($signed(cell_cfg[gpp_pkg::REG_SOURCE_TOP]));
        sw = int'(cell_cfg[gpp_pkg::REG_SOURCE_WIDTH][5:0]);
        sr = int'(cell_cfg[gpp_pkg::REG_SOURCE_ROWS][5:0]);
        if (sw > gpp_pkg::MAX_SOURCE_WIDTH) sw = gpp_pkg::MAX_SOURCE_WIDTH;
        if (sr > gpp_pkg::MAX_SOURCE_ROWS) sr = gpp_pkg::MAX_SOURCE_ROWS;
    endfunction

    function automatic bit bpp_ok(input int bpp);
        return bpp == 1 || bpp == 2 || bpp == 4 || bpp == 8;
    endfunction

    // walk the next byte's worth of cell pixels and advance the cursor
    function automatic gpp_pkg::result_t pack_next_byte();
        int               cw, ch, bpp, left, top_row, sw, sr;
        int               ppb, total, first;
        logic [7:0]       acc;
        logic [7:0]       px;
        gpp_pkg::result_t r;
        decode_cell(cw, ch, bpp, left, top_row, sw, sr);
        r = '0;
        if (pen_x >= cw || pen_y >= ch) begin
            pen_x = 0;
            pen_y = 0;
        end
        if (!bpp_ok(bpp)) begin
            pen_x   = 0;
            pen_y   = 0;
            r.error = 1'b1;
            return r;
        end
        ppb   = gpp_pkg::BYTE_BITS / bpp;
        total = cw * ch;
        first = pen_y * cw + pen_x;
        acc   = '0;
        for (int n = 0; n < ppb; n++) begin
            px = '0;
            if (first + n < total) begin
                if (pen_x >= left && pen_x < left + sw && pen_y >= top_row
                        && pen_y < top_row + sr)
                    px = glyph_px[(pen_y - top_row) * gpp_pkg::MAX_SOURCE_WIDTH
                                  + (pen_x - left)] >> (gpp_pkg::BYTE_BITS - bpp);
                pen_x++;
                if (pen_x >= cw) begin
                    pen_x = 0;
                    pen_y++;
                end
            end else begin
                r.error = 1'b1;
            end
            acc = (acc << bpp) | px;
        end
        if (first + ppb >= total) begin
            r.last_byte = 1'b1;
            pen_x       = 0;
            pen_y       = 0;
        end
        r.packed_byte = acc;
        return r;
    endfunction

    function automatic int next_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 15);
        if (roll < 10) return 0;
        if (roll < 14) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // command driver: hold start until taken, then idle or issue the next one
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                if (cmd.opcode == gpp_pkg::OP_EMIT)
                    expected_bytes.push_back(pack_next_byte());
                else
                    glyph_px[int'(cmd.source_row) * gpp_pkg::MAX_SOURCE_WIDTH
                             + int'(cmd.source_col)] = cmd.pixel_value;
                cmds_taken++;
            end
            if (!(start && busy)) begin
                if (hold_off > 0) begin
                    start <= 1'b0;
                    hold_off--;
                end else if (cmd_backlog.size() != 0) begin
                    cmd      <= cmd_backlog.pop_front();
                    start    <= 1'b1;
                    hold_off = next_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin : check_blk
        gpp_pkg::result_t want;
        if (rst_n && result_valid) begin
            if (expected_bytes.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none, got byte %02h last %0d err %0d",
                         $time, result.packed_byte, result.last_byte, result.error);
            end else begin
                want = expected_bytes.pop_front();
                if (result.packed_byte !== want.packed_byte
                        || result.last_byte !== want.last_byte
                        || result.error !== want.error) begin
                    failures++;
                    $display("%0t: mismatch, expected byte %02h last %0d err %0d,",
                             $time, want.packed_byte, want.last_byte, want.error,
                             " got byte %02h last %0d err %0d",
                             result.packed_byte, result.last_byte, result.error);
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_load(input int row, input int col, input logic [7:0] val);
        gpp_pkg::cmd_t c;
        c.opcode      = gpp_pkg::OP_LOAD;
        c.source_row  = 5'(row);
        c.source_col  = 5'(col);
        c.pixel_value = val;
        cmd_backlog.push_back(c);
        src_loaded[row * gpp_pkg::MAX_SOURCE_WIDTH + col] = 1'b1;
        cmds_queued++;
        gen_items++;
    endtask

    // the load fields ride along unused on an emit; keep them random
    task automatic push_emit();
        gpp_pkg::cmd_t c;
        c             = $bits(gpp_pkg::cmd_t)'($urandom);
        c.opcode      = gpp_pkg::OP_EMIT;
        cmd_backlog.push_back(c);
        cmds_queued++;
        gen_items++;
    endtask

    // wait until every transaction is taken and every byte has come back
    task automatic drain();
        while (cmds_taken != cmds_queued || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cell_cfg[idx] = val & reg_mask(idx);
    endtask

    function automatic void plan_cfg(input int cw, input int ch, input int bpp,
                                     input int left, input int top, input int base,
                                     input int sw, input int sr);
        phase_cfg[gpp_pkg::REG_CELL_WIDTH]     = 7'(cw);
        phase_cfg[gpp_pkg::REG_CELL_HEIGHT]    = 7'(ch);
        phase_cfg[gpp_pkg::REG_BITS_PER_PIXEL] = 7'(bpp);
        phase_cfg[gpp_pkg::REG_SOURCE_LEFT]    = 7'(left);
        phase_cfg[gpp_pkg::REG_SOURCE_TOP]     = 7'(top);
        phase_cfg[gpp_pkg::REG_BASELINE_ROW]   = 7'(base);
        phase_cfg[gpp_pkg::REG_SOURCE_WIDTH]   = 7'(sw);
        phase_cfg[gpp_pkg::REG_SOURCE_ROWS]    = 7'(sr);
    endfunction

    // reconfigure while idle, fill the part of the window the cell can read,
    // then mix emits with stray loads
    task automatic run_phase(input int n_emits, input int n_loads, input bit refresh);
        int cw, ch, bpp, left, top_row, sw, sr;
        int x, y, e_left, l_left;
        drain();
        for (int i = 0; i < 8; i++)
            write_cfg(3'(i), phase_cfg[i]);
        cfg_valid <= 1'b0;
        decode_cell(cw, ch, bpp, left, top_row, sw, sr);
        for (int r = 0; r < sr; r++) begin
            for (int c = 0; c < sw; c++) begin
                x = left + c;
                y = top_row + r;
                if (x >= 0 && x < cw && y >= 0 && y < ch
                        && (refresh || !src_loaded[r * gpp_pkg::MAX_SOURCE_WIDTH + c]))
                    push_load(r, c, 8'($urandom));
            end
        end
        e_left = n_emits;
        l_left = n_loads;
        while (e_left + l_left > 0) begin
            if ($urandom_range(1, e_left + l_left) <= l_left) begin
                push_load($urandom_range(0, 31), $urandom_range(0, 31), 8'($urandom));
                l_left--;
            end else begin
                push_emit();
                e_left--;
            end
        end
    endtask

    initial begin : stimulus
        int cw, ch, bpp, left, top_row, sw, sr;
        int ppb, per_cell, cap, n_emits, rand_goal;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty window, so the bytes are all zero
        push_load(0, 0, 8'hFF);
        push_load(31, 31, 8'h00);
        push_load(0, 31, 8'hAA);
        push_load(31, 0, 8'h55);
        push_emit();
        push_emit();

        // zero width counts as one column; run past the cell end at 8 bpp
        plan_cfg(0, 3, 8, 0, 0, 0, 1, 2);
        run_phase(4, 0, 1'b0);
        // three-pixel cell at 1 bpp: every byte is partial
        plan_cfg(3, 1, 1, 0, 0, 0, 63, 63);
        run_phase(2, 0, 1'b0);
        // oversized cell, window pushed fully out, zero depth
        plan_cfg(63, 63, 0, -32, -32, 0, 0, 0);
        run_phase(2, 0, 1'b0);
        // zero height, illegal depth, window beyond the right edge
        plan_cfg(2, 0, 15, 32, 32, 32, 4, 4);
        run_phase(1, 0, 1'b0);
        // park the cursor mid-cell, then shrink the cell under it
        plan_cfg(4, 4, 2, 0, 0, 0, 0, 0);
        run_phase(2, 0, 1'b0);
        plan_cfg(4, 1, 2, 0, 0, 0, 0, 0);
        run_phase(1, 0, 1'b0);

        rand_goal = gen_items + RAND_ITEMS;
        while (gen_items < rand_goal) begin
            plan_cfg(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                 : (1 << $urandom_range(0, 3)),
                     ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, 6) - 2,
                     ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, 4) - 2,
                     ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, 4),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, 6),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, 6));
            no_idle = ($urandom_range(0, 3) == 0);
            // size the emit count from the planned cell, as the registers will hold it
            cw  = int'(phase_cfg[gpp_pkg::REG_CELL_WIDTH][5:0]);
            ch  = int'(phase_cfg[gpp_pkg::REG_CELL_HEIGHT][5:0]);
            bpp = int'(phase_cfg[gpp_pkg::REG_BITS_PER_PIXEL][3:0]);
            cw  = (cw < 1) ? 1 : (cw > gpp_pkg::MAX_CELL_SIZE) ? gpp_pkg::MAX_CELL_SIZE : cw;
            ch  = (ch < 1) ? 1 : (ch > gpp_pkg::MAX_CELL_SIZE) ? gpp_pkg::MAX_CELL_SIZE : ch;
            ppb = bpp_ok(bpp) ? gpp_pkg::BYTE_BITS / bpp : cw * ch;
            per_cell = (cw * ch + ppb - 1) / ppb;
            cap = 2 * per_cell + 1;
            if (cap > 40) cap = 40;
            n_emits = $urandom_range(1, cap);
            run_phase(n_emits, $urandom_range(0, n_emits / 3 + 1),
                      (cw * ch <= 96) && ($urandom_range(0, 1) == 1));
        end

        drain();
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gpp_pkg.sv
rtl/glyph_place_and_pixel_pack_top.sv
rtl/gpp_checker.sv
verif/glyph_place_and_pixel_pack_top_tb.sv
